FILE: rtl/ult_pkg.sv
// ----------------------------------------------------------------------------
// ult_pkg: shared types and constants for the unordered list table
// Command codes, controller states and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package ult_pkg;

  localparam int ValueW = 32;
  localparam int CountW = 5;
  localparam int CmdW   = 2;
  localparam int AddrW  = 3;

  // register map (index = paddr[2])
  localparam logic REG_CAPACITY = 1'b0;

  localparam logic [CountW-1:0] CapacityReset = 5'd16;

  typedef enum logic [CmdW-1:0] {
    CMD_APPEND = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CMP  = 4'b0010,
    ST_MOVE = 4'b0100,
    ST_RESP = 4'b1000
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/ult_ram.sv
// ----------------------------------------------------------------------------
// ult_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ult_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/unordered_list_table_unit.sv
// ----------------------------------------------------------------------------
// unordered_list_table_unit: unordered table of signed 32-bit values
// Append, search (lowest index) and remove-all (move last into the hole).
//
//  channel   dir  fields (low bit up)              transaction when
//  s_axis    in   tuser: command  tdata: value     tvalid & tready
//  m_axis    out  tuser: ok       tdata: position  tvalid & tready
//  apb       in   pwdata[4:0]: capacity @ 0x0      psel & penable & pwrite
//
// Append writes the RAM as the command is taken, then passes through ST_RESP
// to the output register. Search compares one stored entry per cycle through
// the RAM read port. Remove-all scans the same way; each removal reads the
// last entry and writes it into the hole in ST_MOVE. The table RAM needs no
// clearing after reset; capacity resets to 16. A stalled output holds one
// result while the next command is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module unordered_list_table_unit
  import ult_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // command stream
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [ValueW-1:0] s_axis_tdata,   // [31:0] value
  input  wire logic [CmdW-1:0]   s_axis_tuser,   // [1:0] command
  // result stream
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [7:0]             m_axis_tdata,   // [4:0] position, [7:5] zero
  output logic                   m_axis_tuser,   // [0] ok
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [CountW-1:0] DepthSat = (DEPTH > 31) ? 5'd31 : 5'(DEPTH);

  function automatic logic [AW-1:0] to_addr(input logic [CountW-1:0] c);
    logic [AW+CountW-1:0] w;
    w = {{AW{1'b0}}, c};
    return w[AW-1:0];
  endfunction

  state_e              state_q, state_d;
  logic                rmv_q, rmv_d;        // 1: remove-all, 0: search
  logic [ValueW-1:0]   val_q, val_d;
  logic [CountW-1:0]   idx_q, idx_d;
  logic [CountW-1:0]   cnt_q, cnt_d;
  logic                hit_q, hit_d;
  logic                res_ok_q, res_ok_d;
  logic [CountW-1:0]   res_pos_q, res_pos_d;
  logic                m_valid_q, m_valid_d;
  logic                out_ok_q, out_ok_d;
  logic [CountW-1:0]   out_pos_q, out_pos_d;
  logic [CountW-1:0]   cap_q;
  logic                fwd_q;
  logic [ValueW-1:0]   fwd_data_q;

  logic                we, re;
  logic [AW-1:0]       waddr, raddr;
  logic [ValueW-1:0]   wdata, ram_rdata, rdata;
  logic [CountW-1:0]   eff_cap, idx_inc, cnt_dec;
  logic                in_hs, cfg_wr, match, more;

  // ---------------------------------------------------------------- config
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_CAPACITY) ? {27'd0, cap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapacityReset;
    end else if (cfg_wr && paddr[2] == REG_CAPACITY) begin
      cap_q <= pwdata[CountW-1:0];
    end
  end

  assign eff_cap = (int'(cap_q) < DEPTH) ? cap_q : DepthSat;

  // ---------------------------------------------------------------- table
  ult_ram #(
    .WIDTH (ValueW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // read of the entry written in the same cycle gets the new data
  assign rdata = fwd_q ? fwd_data_q : ram_rdata;

  always_ff @(posedge clk_i) begin
    fwd_q      <= we && re && (waddr == raddr);
    fwd_data_q <= wdata;
  end

  // ---------------------------------------------------------------- control
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_hs   = s_axis_tvalid && s_axis_tready;
  assign idx_inc = 5'(idx_q + 5'd1);
  assign cnt_dec = 5'(cnt_q - 5'd1);
  assign match   = (rdata == val_q);
  assign more    = (idx_inc < cnt_q);

  always_comb begin
    state_d   = state_q;
    rmv_d     = rmv_q;
    val_d     = val_q;
    idx_d     = idx_q;
    cnt_d     = cnt_q;
    hit_d     = hit_q;
    res_ok_d  = res_ok_q;
    res_pos_d = res_pos_q;
    we        = 1'b0;
    waddr     = to_addr(cnt_q);
    wdata     = s_axis_tdata;
    re        = 1'b0;
    raddr     = to_addr(idx_inc);

    case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          val_d     = s_axis_tdata;
          idx_d     = '0;
          hit_d     = 1'b0;
          res_ok_d  = 1'b0;
          res_pos_d = '0;
          state_d   = ST_RESP;
          case (cmd_e'(s_axis_tuser))
            CMD_APPEND: begin
              if (cnt_q < eff_cap) begin
                we        = 1'b1;
                cnt_d     = 5'(cnt_q + 5'd1);
                res_ok_d  = 1'b1;
                res_pos_d = 5'(cnt_q + 5'd1);
              end
            end
            CMD_SEARCH, CMD_REMOVE: begin
              rmv_d = (cmd_e'(s_axis_tuser) == CMD_REMOVE);
              if (cnt_q != '0) begin
                re      = 1'b1;
                raddr   = to_addr('0);
                state_d = ST_CMP;
              end
            end
            default: ;
          endcase
        end
      end

      ST_CMP: begin
        if (match && !rmv_q) begin
          res_ok_d  = 1'b1;
          res_pos_d = idx_q;
          state_d   = ST_RESP;
        end else if (match) begin
          // fetch the last entry to fill the hole
          cnt_d   = cnt_dec;
          hit_d   = 1'b1;
          re      = 1'b1;
          raddr   = to_addr(cnt_dec);
          state_d = ST_MOVE;
        end else if (more) begin
          idx_d = idx_inc;
          re    = 1'b1;
        end else begin
          res_ok_d  = rmv_q && hit_q;
          res_pos_d = rmv_q ? cnt_q : '0;
          state_d   = ST_RESP;
        end
      end

      ST_MOVE: begin
        // rdata is the former last entry, now stored at idx
        we    = 1'b1;
        waddr = to_addr(idx_q);
        wdata = rdata;
        if ((idx_q < cnt_q) && match) begin
          cnt_d = cnt_dec;
          re    = 1'b1;
          raddr = to_addr(cnt_dec);
        end else if ((idx_q < cnt_q) && more) begin
          idx_d   = idx_inc;
          re      = 1'b1;
          state_d = ST_CMP;
        end else begin
          res_ok_d  = hit_q;
          res_pos_d = cnt_q;
          state_d   = ST_RESP;
        end
      end

      ST_RESP: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    m_valid_d = m_valid_q;
    out_ok_d  = out_ok_q;
    out_pos_d = out_pos_q;
    if (m_valid_q && m_axis_tready) begin
      m_valid_d = 1'b0;
    end
    if (state_q == ST_RESP && (!m_valid_q || m_axis_tready)) begin
      m_valid_d = 1'b1;
      out_ok_d  = res_ok_q;
      out_pos_d = res_pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rmv_q     <= rmv_d;
    val_q     <= val_d;
    idx_q     <= idx_d;
    hit_q     <= hit_d;
    res_ok_q  <= res_ok_d;
    res_pos_q <= res_pos_d;
    out_ok_q  <= out_ok_d;
    out_pos_q <= out_pos_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = out_ok_q;
  assign m_axis_tdata  = {3'd0, out_pos_q};

  // ---------------------------------------------------------------- checks
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthSat)
    else $error("count exceeds table depth");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CMP) |-> (idx_q < cnt_q))
    else $error("scan index beyond count");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> (cnt_q == 5'($past(cnt_q) + 5'd1) ||
                         cnt_q == 5'($past(cnt_q) - 5'd1)))
    else $error("count moved by more than one");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside response state");

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for unordered_list_table_unit
// Streams append, search, remove-all and unused commands with random gaps on
// both sides and compares every result against a cycle-free model of the list.
// Capacity is rewritten between phases over APB while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import ult_pkg::*;

  localparam int TableDepth = 16;
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 60;
  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam logic REG_SPARE = 1'b1;
  localparam logic [ValueW-1:0] ValMin = 32'h8000_0000;
  localparam logic [ValueW-1:0] ValMax = 32'h7fff_ffff;

  typedef struct packed {
    logic [CmdW-1:0]   cmd;
    logic [ValueW-1:0] value;
  } command_t;

  typedef struct packed {
    logic              ok;
    logic [CountW-1:0] position;
  } reply_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ValueW-1:0] s_axis_tdata  = '0;  // [31:0] value
  logic [CmdW-1:0]   s_axis_tuser  = '0;  // [1:0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;        // [4:0] position, [7:5] zero
  logic              m_axis_tuser;        // [0] ok
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [AddrW-1:0]  paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  command_t          cmd_q[$];
  reply_t            reply_q[$];
  logic [ValueW-1:0] slots_q[TableDepth];
  logic [CountW-1:0] fill_cnt   = '0;
  logic [CountW-1:0] capacity_q = CapacityReset;
  int                cycle_cnt  = 0;
  int                err_cnt    = 0;

  unordered_list_table_unit #(.DEPTH(TableDepth)) i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- list model
  function automatic int lowest_match(logic [ValueW-1:0] v);
    for (int i = 0; i < fill_cnt; i++) begin
      if (slots_q[i] == v) return i;
    end
    return -1;
  endfunction

  function automatic reply_t apply_command(command_t c);
    reply_t            r;
    int                idx;
    logic [CountW-1:0] room;
    r    = '0;
    room = (capacity_q < TableDepth) ? capacity_q : CountW'(TableDepth);
    case (c.cmd)
      CMD_APPEND: begin
        if (fill_cnt < room) begin
          slots_q[fill_cnt] = c.value;
          fill_cnt = fill_cnt + 1'b1;
          r.ok = 1'b1;
          r.position = fill_cnt;
        end
      end
      CMD_SEARCH: begin
        idx = lowest_match(c.value);
        if (idx >= 0) begin
          r.ok = 1'b1;
          r.position = CountW'(idx);
        end
      end
      CMD_REMOVE: begin
        // last entry fills the hole, then rescan from the bottom
        idx = lowest_match(c.value);
        while (idx >= 0 && fill_cnt > 0) begin
          fill_cnt = fill_cnt - 1'b1;
          slots_q[idx] = slots_q[fill_cnt];
          r.ok = 1'b1;
          idx = lowest_match(c.value);
        end
        r.position = fill_cnt;
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------- gaps
  function automatic bit take_gap();
    // long stretch with no idling on either side
    if (cycle_cnt >= 4000 && cycle_cnt < 10000) return 1'b0;
    return $urandom_range(99) < 22;
  endfunction

  // ---------------------------------------------------------------- driver
  always @(posedge clk_i) begin : drive_cmd
    command_t nxt;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (cmd_q.size() > 0 && !take_gap()) begin
          nxt = cmd_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt.value;
          s_axis_tuser  <= nxt.cmd;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= !take_gap();
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk_i) begin : watch
    reply_t exp_r;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        reply_q.push_back(apply_command('{cmd: s_axis_tuser, value: s_axis_tdata}));
      if (m_axis_tvalid && m_axis_tready) begin
        if (reply_q.size() == 0) begin
          if (err_cnt < 10)
            $display("tb: unexpected result ok %0b tdata %0h", m_axis_tuser, m_axis_tdata);
          err_cnt++;
        end else begin
          exp_r = reply_q.pop_front();
          if (m_axis_tuser !== exp_r.ok || m_axis_tdata !== {3'b000, exp_r.position}) begin
            if (err_cnt < 10)
              $display("tb: mismatch ok exp %0b got %0b, position exp %0d got tdata %0d",
                       exp_r.ok, m_axis_tuser, exp_r.position, m_axis_tdata);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic push(logic [CmdW-1:0] cmd, logic [ValueW-1:0] value);
    cmd_q.push_back('{cmd: cmd, value: value});
  endtask

  task automatic wait_drained(int extra);
    do @(negedge clk_i);
    while (cmd_q.size() > 0 || s_axis_tvalid || reply_q.size() > 0);
    repeat (extra) @(negedge clk_i);
  endtask

  task automatic apb_write(logic idx, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CAPACITY) capacity_q = data[CountW-1:0];
  endtask

  function automatic command_t random_command(int append_pct,
                                              logic [ValueW-1:0] pool[5]);
    command_t c;
    int       r;
    r = $urandom_range(99);
    if (r < append_pct)                          c.cmd = CMD_APPEND;
    else if (r < append_pct + (95 - append_pct) / 2) c.cmd = CMD_SEARCH;
    else if (r < 95)                             c.cmd = CMD_REMOVE;
    else                                         c.cmd = CMD_UNUSED;
    r = $urandom_range(99);
    if (r < 70)      c.value = pool[$urandom_range(4)];
    else if (r < 90) c.value = $urandom;
    else begin
      case ($urandom_range(3))
        0:       c.value = ValMin;
        1:       c.value = ValMax;
        2:       c.value = '0;
        default: c.value = '1;
      endcase
    end
    return c;
  endfunction

  initial begin : stimulus
    logic [ValueW-1:0] pool[5];
    logic [CountW-1:0] caps[11];
    int                append_pct;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extremes, duplicates, unused command
    push(CMD_SEARCH, '0);
    push(CMD_REMOVE, 32'd5);
    push(CMD_UNUSED, ValMax);
    push(CMD_APPEND, ValMin);
    push(CMD_APPEND, ValMax);
    push(CMD_APPEND, '0);
    push(CMD_APPEND, '1);
    push(CMD_APPEND, ValMin);
    push(CMD_SEARCH, ValMax);
    push(CMD_SEARCH, ValMin);
    push(CMD_SEARCH, 32'd12345);
    push(CMD_REMOVE, ValMin);
    push(CMD_REMOVE, 32'd777);
    push(CMD_SEARCH, '1);
    wait_drained(SettleCycles);

    // capacity below the fill level: appends fail until entries go
    apb_write(REG_CAPACITY, 32'hffff_ffe2);
    push(CMD_APPEND, 32'd42);
    push(CMD_REMOVE, '1);
    push(CMD_APPEND, 32'd42);
    wait_drained(SettleCycles);
    apb_write(REG_SPARE, '0);  // ignored register index
    push(CMD_REMOVE, '0);
    push(CMD_APPEND, 32'd42);
    push(CMD_APPEND, 32'd43);
    wait_drained(SettleCycles);

    caps = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd8, 5'd16, 5'd2, 5'd0, 5'd0, 5'd0, 5'd0};
    for (int k = 7; k < 11; k++) caps[k] = CountW'($urandom_range(31));
    for (int ph = 0; ph < 11; ph++) begin
      // random upper bits, capacity in the low five
      apb_write(REG_CAPACITY, {27'($urandom), caps[ph]});
      foreach (pool[j]) pool[j] = $urandom;
      append_pct = (ph % 2) ? 65 : 40;
      for (int n = 0; n < 180; n++) cmd_q.push_back(random_command(append_pct, pool));
      wait_drained(SettleCycles);
    end

    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
